FILE: rtl/core/uniform_grid_bin_and_neighbors_unit_defines.svh
// ----------------------------------------------------------------------------
// Uniform grid binning unit: assertion macros
// Shared property shorthands for the clocked checks of the grid binning unit.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_GRID_BIN_AND_NEIGHBORS_UNIT_DEFINES_SVH
`define UNIFORM_GRID_BIN_AND_NEIGHBORS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UGBN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UGBN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ugbn_pkg.sv
// ----------------------------------------------------------------------------
// Uniform grid binning package
// Field widths, request and register codes, and the transfer payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package ugbn_pkg;

    localparam int MAX_AXIS_BITS = 4;
    localparam int MIN_AXIS_BITS = 2;
    localparam int CELL_W        = 3 * MAX_AXIS_BITS;
    localparam int COORD_W       = 16;
    localparam int INV_W         = 16;
    localparam int INV_FRAC_BITS = 8;
    localparam int LOG2_W        = 3;
    localparam int REQ_W         = 2;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [REQ_W-1:0] REQ_POINT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRI   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_LOG2_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOG2_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOG2_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_X  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_Y  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_Z  = 3'd5;

    localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd4;
    localparam logic [INV_W-1:0]  INV_RESET  = 16'd256;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COORD_W-1:0] v0_x;
        logic [COORD_W-1:0] v0_y;
        logic [COORD_W-1:0] v0_z;
        logic [COORD_W-1:0] v1_x;
        logic [COORD_W-1:0] v1_y;
        logic [COORD_W-1:0] v1_z;
        logic [COORD_W-1:0] v2_x;
        logic [COORD_W-1:0] v2_y;
        logic [COORD_W-1:0] v2_z;
        logic [CELL_W-1:0]  query_cell;
    } t_req;

    typedef struct packed {
        logic [CELL_W-1:0] cell_out;
        logic              out_valid;
        logic              out_last;
    } t_rsp;

endpackage

`default_nettype wire

FILE: rtl/core/uniform_grid_bin_and_neighbors_unit.sv
// ----------------------------------------------------------------------------
// Uniform grid binning and neighbour query unit
// Requests arrive on i_valid/o_ready with an i_req payload; results leave on
// o_valid/i_ready with an o_rsp payload. Registers are written through the
// i_cfg_valid/o_cfg_ready channel, which always accepts a transfer.
// A point or triangle insert quantises each axis in turn on one shared
// multiplier (a triangle needs a second pass for the division by three
// unless its sum saturates), marks the cell occupied and returns one result.
// A neighbour query scans the 27 surrounding cells through the single read
// port of the occupancy memory, one cell a cycle while the receiver takes
// results, and returns each occupied cell in turn, or one invalid result.
// One request is in flight at a time; the next is accepted once the
// previous one is finished, even while its last result still waits in the
// output register. After reset a clearing pass writes all 4096 cells of
// the occupancy memory empty before the first request is accepted.
// While the receiver stalls, the result holds and the scan pauses.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uniform_grid_bin_and_neighbors_unit_defines.svh"

module uniform_grid_bin_and_neighbors_unit #(
    parameter int COORD_FRAC_BITS = 6
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  ugbn_pkg::t_req                        i_req,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output ugbn_pkg::t_rsp                        o_rsp,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [ugbn_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire  [ugbn_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int M           = ugbn_pkg::MAX_AXIS_BITS;
    localparam int CELL_W      = ugbn_pkg::CELL_W;
    localparam int LOG2_W      = ugbn_pkg::LOG2_W;
    localparam int INV_W       = ugbn_pkg::INV_W;
    localparam int COORD_W     = ugbn_pkg::COORD_W;
    localparam int MUL_A_W     = COORD_W + 2;
    localparam int PROD_W      = MUL_A_W + INV_W;
    localparam int QSHIFT      = COORD_FRAC_BITS + ugbn_pkg::INV_FRAC_BITS;
    localparam int TN_W        = M + 2;
    localparam int DIV3_SHIFT  = 2 * (M + 2);
    localparam int DIV3_MUL    = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int CELL_COUNT  = 1 << CELL_W;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] DIG_HI = 2'd2;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_QNT    = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_WRITE  = 9'b000100000,
        S_QSCAN  = 9'b001000000,
        S_QFLUSH = 9'b010000000,
        S_QEND   = 9'b100000000
    } t_state;

    function automatic logic [LOG2_W-1:0] eff_bits(input logic [LOG2_W-1:0] v);
        logic [LOG2_W-1:0] r;
        if (v < LOG2_W'(ugbn_pkg::MIN_AXIS_BITS)) begin
            r = LOG2_W'(ugbn_pkg::MIN_AXIS_BITS);
        end else if (v > LOG2_W'(M)) begin
            r = LOG2_W'(M);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_of(input logic [M-1:0] x,
                                                  input logic [M-1:0] y,
                                                  input logic [M-1:0] z,
                                                  input logic [LOG2_W-1:0] sh_z,
                                                  input logic [LOG2_W:0] sh_y);
        logic [CELL_W-1:0] c;
        c = CELL_W'(x) + (CELL_W'(z) << sh_z) + (CELL_W'(y) << sh_y);
        return c;
    endfunction

    t_state                r_state, n_state;
    logic [CELL_W-1:0]     r_clr;
    logic [LOG2_W-1:0]     r_log2_x, r_log2_y, r_log2_z;
    logic [INV_W-1:0]      r_inv_x, r_inv_y, r_inv_z;
    ugbn_pkg::t_req        r_req;
    logic [1:0]            r_axis;
    logic [PROD_W-1:0]     r_prod;
    logic [M-1:0]          r_q [3];
    logic [1:0]            r_dx, r_dy, r_dz;
    logic                  r_rd_pend;
    logic [CELL_W-1:0]     r_rd_cell;
    logic                  r_rd_data;
    logic                  r_have;
    logic [CELL_W-1:0]     r_hold;
    logic                  r_out_vld;
    ugbn_pkg::t_rsp        r_out;
    logic                  r_occ [CELL_COUNT];

    logic [LOG2_W-1:0]     bx, by, bz;
    logic [LOG2_W:0]       sh_xz;
    logic [LOG2_W+1:0]     sh_all;
    logic [M:0]            size_x, size_y, size_z;
    logic                  accept, out_free, is_tri, hit, last_nb, q_ok_in;
    logic [MUL_A_W-1:0]    cur_sum, mul_a;
    logic [INV_W-1:0]      cur_inv, mul_b;
    logic [M:0]            cur_size;
    logic [M+2:0]          cur_size3;
    logic [PROD_W-1:0]     mul_p, t_val;
    logic                  sat, q_store;
    logic [M-1:0]          q_val;
    logic [M-1:0]          cx, cy, cz, nx, ny, nz;
    logic [M:0]            nx_p, ny_p, nz_p;
    logic                  nb_ok;
    logic [CELL_W-1:0]     nb_cell, ins_cell;
    logic                  mem_we, mem_wdata, mem_re;
    logic [CELL_W-1:0]     mem_waddr;
    logic                  out_push;
    ugbn_pkg::t_rsp        push_rsp;

    assign bx     = eff_bits(r_log2_x);
    assign by     = eff_bits(r_log2_y);
    assign bz     = eff_bits(r_log2_z);
    assign sh_xz  = (LOG2_W + 1)'(bx) + (LOG2_W + 1)'(bz);
    assign sh_all = (LOG2_W + 2)'(sh_xz) + (LOG2_W + 2)'(by);
    assign size_x = (M + 1)'(1) << bx;
    assign size_y = (M + 1)'(1) << by;
    assign size_z = (M + 1)'(1) << bz;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_vld;
    assign o_rsp       = r_out;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_vld || i_ready;
    assign is_tri   = (r_req.req_type == ugbn_pkg::REQ_TRI);
    assign hit      = r_rd_pend && r_rd_data;
    assign last_nb  = (r_dx == DIG_HI) && (r_dz == DIG_HI) && (r_dy == DIG_HI);
    assign q_ok_in  = (i_req.query_cell >> sh_all) == '0;

    always_comb begin
        cur_sum  = MUL_A_W'(r_req.v0_x);
        cur_inv  = r_inv_x;
        cur_size = size_x;
        case (r_axis)
            AXIS_Y: begin
                cur_sum  = is_tri ? MUL_A_W'(r_req.v0_y) + MUL_A_W'(r_req.v1_y)
                                    + MUL_A_W'(r_req.v2_y)
                                  : MUL_A_W'(r_req.v0_y);
                cur_inv  = r_inv_y;
                cur_size = size_y;
            end
            AXIS_Z: begin
                cur_sum  = is_tri ? MUL_A_W'(r_req.v0_z) + MUL_A_W'(r_req.v1_z)
                                    + MUL_A_W'(r_req.v2_z)
                                  : MUL_A_W'(r_req.v0_z);
                cur_inv  = r_inv_z;
                cur_size = size_z;
            end
            default: begin
                cur_sum  = is_tri ? MUL_A_W'(r_req.v0_x) + MUL_A_W'(r_req.v1_x)
                                    + MUL_A_W'(r_req.v2_x)
                                  : MUL_A_W'(r_req.v0_x);
                cur_inv  = r_inv_x;
                cur_size = size_x;
            end
        endcase
    end

    assign cur_size3 = ((M + 3)'(cur_size) << 1) + (M + 3)'(cur_size);
    assign t_val     = r_prod >> QSHIFT;
    assign sat       = is_tri ? (t_val >= PROD_W'(cur_size3)) : (t_val >= PROD_W'(cur_size));
    assign q_store   = ((r_state == S_QNT) && (sat || !is_tri)) || (r_state == S_DIV);

    always_comb begin
        if (r_state == S_DIV) begin
            q_val = M'(r_prod >> DIV3_SHIFT);
        end else if (sat) begin
            q_val = M'(cur_size - 1'b1);
        end else begin
            q_val = t_val[M-1:0];
        end
    end

    assign mul_a = (r_state == S_QNT) ? MUL_A_W'(t_val[TN_W-1:0]) : cur_sum;
    assign mul_b = (r_state == S_QNT) ? INV_W'(DIV3_MUL) : cur_inv;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign cx   = M'(r_req.query_cell) & M'(size_x - 1'b1);
    assign cz   = M'(r_req.query_cell >> bx) & M'(size_z - 1'b1);
    assign cy   = M'(r_req.query_cell >> sh_xz);
    assign nx_p = (M + 1)'(cx) + (M + 1)'(r_dx);
    assign ny_p = (M + 1)'(cy) + (M + 1)'(r_dy);
    assign nz_p = (M + 1)'(cz) + (M + 1)'(r_dz);
    assign nx   = M'(nx_p - 1'b1);
    assign ny   = M'(ny_p - 1'b1);
    assign nz   = M'(nz_p - 1'b1);
    assign nb_ok = (nx_p != '0) && (nx_p <= size_x)
                && (ny_p != '0) && (ny_p <= size_y)
                && (nz_p != '0) && (nz_p <= size_z);
    assign nb_cell  = cell_of(nx, ny, nz, bx, sh_xz);
    assign ins_cell = cell_of(r_q[AXIS_X], r_q[AXIS_Y], r_q[AXIS_Z], bx, sh_xz);

    always_comb begin
        n_state            = r_state;
        mem_we             = 1'b0;
        mem_wdata          = 1'b0;
        mem_waddr          = r_clr;
        mem_re             = 1'b0;
        out_push           = 1'b0;
        push_rsp.cell_out  = r_hold;
        push_rsp.out_valid = 1'b1;
        push_rsp.out_last  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_req.req_type) inside
                        ugbn_pkg::REQ_POINT, ugbn_pkg::REQ_TRI: n_state = S_MUL;
                        ugbn_pkg::REQ_QUERY: n_state = q_ok_in ? S_QSCAN : S_QEND;
                        default: n_state = S_QEND;
                    endcase
                end
            end
            S_MUL: begin
                n_state = S_QNT;
            end
            S_QNT: begin
                if (q_store) begin
                    n_state = (r_axis == AXIS_Z) ? S_WRITE : S_MUL;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_state = (r_axis == AXIS_Z) ? S_WRITE : S_MUL;
            end
            S_WRITE: begin
                if (out_free) begin
                    mem_we             = 1'b1;
                    mem_wdata          = 1'b1;
                    mem_waddr          = ins_cell;
                    out_push           = 1'b1;
                    push_rsp.cell_out  = ins_cell;
                    push_rsp.out_last  = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_QSCAN: begin
                if (out_free) begin
                    mem_re   = 1'b1;
                    out_push = hit && r_have;
                    if (last_nb) begin
                        n_state = S_QFLUSH;
                    end
                end
            end
            S_QFLUSH: begin
                if (out_free) begin
                    out_push = hit && r_have;
                    n_state  = S_QEND;
                end
            end
            S_QEND: begin
                if (out_free) begin
                    out_push           = 1'b1;
                    push_rsp.cell_out  = r_have ? r_hold : '0;
                    push_rsp.out_valid = r_have;
                    push_rsp.out_last  = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_log2_x  <= ugbn_pkg::LOG2_RESET;
            r_log2_y  <= ugbn_pkg::LOG2_RESET;
            r_log2_z  <= ugbn_pkg::LOG2_RESET;
            r_inv_x   <= ugbn_pkg::INV_RESET;
            r_inv_y   <= ugbn_pkg::INV_RESET;
            r_inv_z   <= ugbn_pkg::INV_RESET;
            r_axis    <= AXIS_X;
            r_dx      <= '0;
            r_dy      <= '0;
            r_dz      <= '0;
            r_rd_pend <= 1'b0;
            r_have    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    ugbn_pkg::CFG_LOG2_X: r_log2_x <= i_cfg_data[LOG2_W-1:0];
                    ugbn_pkg::CFG_LOG2_Y: r_log2_y <= i_cfg_data[LOG2_W-1:0];
                    ugbn_pkg::CFG_LOG2_Z: r_log2_z <= i_cfg_data[LOG2_W-1:0];
                    ugbn_pkg::CFG_INV_X:  r_inv_x  <= i_cfg_data[INV_W-1:0];
                    ugbn_pkg::CFG_INV_Y:  r_inv_y  <= i_cfg_data[INV_W-1:0];
                    ugbn_pkg::CFG_INV_Z:  r_inv_z  <= i_cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end

            if (out_push) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state) inside
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_axis    <= AXIS_X;
                        r_dx      <= '0;
                        r_dy      <= '0;
                        r_dz      <= '0;
                        r_rd_pend <= 1'b0;
                        r_have    <= 1'b0;
                    end
                end
                S_QNT, S_DIV: begin
                    if (q_store && (r_axis != AXIS_Z)) begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_QSCAN: begin
                    if (out_free) begin
                        r_rd_pend <= nb_ok;
                        if (hit) begin
                            r_have <= 1'b1;
                        end
                        if (r_dx != DIG_HI) begin
                            r_dx <= r_dx + 1'b1;
                        end else begin
                            r_dx <= '0;
                            if (r_dz != DIG_HI) begin
                                r_dz <= r_dz + 1'b1;
                            end else begin
                                r_dz <= '0;
                                r_dy <= (r_dy != DIG_HI) ? r_dy + 1'b1 : '0;
                            end
                        end
                    end
                end
                S_QFLUSH: begin
                    if (out_free) begin
                        r_rd_pend <= 1'b0;
                        if (hit) begin
                            r_have <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if ((r_state == S_MUL) || (r_state == S_QNT)) begin
            r_prod <= mul_p;
        end
        if (q_store) begin
            r_q[r_axis] <= q_val;
        end
        if ((r_state == S_QSCAN) && out_free) begin
            r_rd_cell <= nb_cell;
        end
        if (((r_state == S_QSCAN) || (r_state == S_QFLUSH)) && out_free && hit) begin
            r_hold <= r_rd_cell;
        end
        if (out_push) begin
            r_out <= push_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_occ[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_occ[nb_cell];
        end
    end

    `UGBN_ASSERT_NEXT(a_insert_result, i_clk, i_rst_n,
        (r_state == S_WRITE) && out_free,
        o_valid && o_rsp.out_valid && o_rsp.out_last,
        "insert did not present a valid final result")

    `UGBN_ASSERT_NEXT(a_empty_query_result, i_clk, i_rst_n,
        (r_state == S_QEND) && out_free && !r_have,
        o_valid && !o_rsp.out_valid && o_rsp.out_last && (o_rsp.cell_out == '0),
        "empty query did not present a single invalid result")

    `UGBN_ASSERT_IMPL(a_digits_in_range, i_clk, i_rst_n,
        1'b1,
        (r_dx != 2'd3) && (r_dy != 2'd3) && (r_dz != 2'd3),
        "neighbour offset counter left its range")

    `UGBN_ASSERT_NEXT(a_flush_to_end, i_clk, i_rst_n,
        r_state == S_QFLUSH,
        (r_state == S_QFLUSH) || (r_state == S_QEND),
        "scan flush did not lead to the final result")

endmodule

`default_nettype wire
